FILE: design/wfs_pkg.sv
// shared types, codes and tables of the weighted fair scheduler table
package wfs_pkg;

    localparam int NUM_SLOTS_DEF = 64;

    localparam logic [2:0] MD_PICK  = 3'd0;
    localparam logic [2:0] MD_WAKE  = 3'd1;
    localparam logic [2:0] MD_WRITE = 3'd2;
    localparam logic [2:0] MD_READ  = 3'd3;
    localparam logic [2:0] MD_SHIFT = 3'd4;

    localparam logic [2:0] RS_SLEEPING = 3'd2;
    localparam logic [2:0] RS_RUNNABLE = 3'd3;
    localparam logic [2:0] RS_RUNNING  = 3'd4;

    localparam logic signed [32:0] SHIFT_STEP = 33'sh0_0FFF_FFFF;
    localparam logic [13:0] SLICE_SCALE = 14'd10000;

    typedef struct packed {
        logic [2:0]         state;
        logic signed [3:0]  nice;
        logic signed [31:0] vr;
        logic [31:0]        chan;
    } t_entry;

    typedef struct packed {
        logic               found;
        logic [5:0]         chosen_slot;
        logic [11:0]        weight;
        logic [13:0]        slice_ticks;
        logic [2:0]         slot_state;
        logic signed [3:0]  slot_nice;
        logic signed [31:0] slot_vruntime;
        logic [6:0]         woken_count;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PK_RD, ST_PK_EV, ST_PK_SET, ST_DIV, ST_PK_WR,
        ST_WK_RD, ST_WK_EV, ST_WK_IRD, ST_WK_IEV, ST_WK_WR,
        ST_SH_RD, ST_SH_EV, ST_RD_AD, ST_RD_EV, ST_DONE
    } t_state;

    // load weight, nice clamped to -5..5
    function automatic logic [11:0] weight_of(input logic signed [3:0] n);
        logic [11:0] w;
        if (n <= -4'sd5) w = 12'd3121;
        else if (n >= 4'sd5) w = 12'd335;
        else begin
            unique case (n)
                -4'sd4:  w = 12'd2501;
                -4'sd3:  w = 12'd1991;
                -4'sd2:  w = 12'd1586;
                -4'sd1:  w = 12'd1277;
                4'sd0:   w = 12'd1024;
                4'sd1:   w = 12'd820;
                4'sd2:   w = 12'd655;
                4'sd3:   w = 12'd526;
                4'sd4:   w = 12'd423;
                default: w = 12'd1024;
            endcase
        end
        return w;
    endfunction

    // 1024000 / weight, same clamp
    function automatic logic [11:0] tick_of(input logic signed [3:0] n);
        logic [11:0] q;
        if (n <= -4'sd5) q = 12'd328;
        else if (n >= 4'sd5) q = 12'd3056;
        else begin
            unique case (n)
                -4'sd4:  q = 12'd409;
                -4'sd3:  q = 12'd514;
                -4'sd2:  q = 12'd645;
                -4'sd1:  q = 12'd801;
                4'sd0:   q = 12'd1000;
                4'sd1:   q = 12'd1248;
                4'sd2:   q = 12'd1563;
                4'sd3:   q = 12'd1946;
                4'sd4:   q = 12'd2420;
                default: q = 12'd1000;
            endcase
        end
        return q;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else r = v[31:0];
        return r;
    endfunction

endpackage

FILE: design/wfs_if.sv
// request and response channel interfaces of the scheduler table
interface wfs_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic [5:0]         slot;
    logic [2:0]         new_state;
    logic signed [3:0]  new_nice;
    logic signed [31:0] new_vruntime;
    logic [31:0]        channel;
    logic               shift_down;
    modport source (output valid, mode, slot, new_state, new_nice, new_vruntime, channel,
                    shift_down, input ready);
    modport sink (input valid, mode, slot, new_state, new_nice, new_vruntime, channel,
                  shift_down, output ready);
endinterface

interface wfs_rsp_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic [5:0]         chosen_slot;
    logic [11:0]        weight;
    logic [13:0]        slice_ticks;
    logic [2:0]         slot_state;
    logic signed [3:0]  slot_nice;
    logic signed [31:0] slot_vruntime;
    logic [6:0]         woken_count;
    modport source (output valid, found, chosen_slot, weight, slice_ticks, slot_state,
                    slot_nice, slot_vruntime, woken_count, input ready);
    modport sink (input valid, found, chosen_slot, weight, slice_ticks, slot_state,
                  slot_nice, slot_vruntime, woken_count, output ready);
endinterface

FILE: design/weighted_fair_scheduler_table.sv
// weighted fair scheduler table: slot memory with a scan sequencer and slice divider
//  channel   dir  payload
//  i_req     in   mode, slot, new_state, new_nice, new_vruntime, channel, shift_down
//  o_rsp     out  found, chosen_slot, weight, slice_ticks, slot_state, slot_nice,
//                 slot_vruntime, woken_count
// one request at a time; memory reads are registered, and scans read then evaluate each slot in turn:
// pick, shift and wake scan every slot, wake rescans every slot for each one it wakes, and a pick
// that finds a runnable slot then runs the divider, which makes a bit a cycle.
// reset clears all slot valid bits, so unwritten slots read as zero; no clearing pass.
// a new request is taken while the previous response waits; the sequencer holds at
// its last step until the response register is free.
module weighted_fair_scheduler_table
    import wfs_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wfs_req_if.sink   i_req,
    wfs_rsp_if.source o_rsp
);
    localparam int IW = $clog2(NUM_SLOTS);
    localparam int TW = 12 + IW;
    localparam int NW = ((TW > 25) ? TW : 25) + 1;
    localparam int CW = $clog2(NW + 1);
    localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS - 1);

    t_entry r_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_vld;
    t_entry r_rd_e;
    logic   r_rd_v;
    t_entry rd_e;

    logic          mem_we;
    logic [IW-1:0] mem_wa, mem_ra;
    t_entry        mem_wd;

    t_state r_state, n_state;
    logic [2:0] r_mode, n_mode;
    logic [5:0] r_slot, n_slot;
    t_entry r_cmd, n_cmd;
    logic r_down, n_down;
    logic [IW-1:0] r_idx, n_idx, r_jdx, n_jdx;
    logic [TW-1:0] r_total, n_total;
    logic r_have, n_have;
    logic [IW-1:0] r_best, n_best;
    t_entry r_best_e, n_best_e;
    t_entry r_cur, n_cur;
    logic signed [31:0] r_min, n_min;
    logic r_other, n_other;
    logic [6:0] r_count, n_count;
    logic [TW-1:0] r_rem, n_rem;
    logic [NW-1:0] r_num, n_num, r_quo, n_quo;
    logic [CW-1:0] r_cnt, n_cnt;
    t_rsp r_res, n_res, r_out, n_out;
    logic r_ov, n_ov;

    logic slot_ok;
    logic [TW:0] rem_sh;
    logic [11:0] wb;
    logic signed [32:0] vsum;

    assign rd_e = r_rd_v ? r_rd_e : '0;
    assign slot_ok = 32'(r_slot) < 32'(NUM_SLOTS);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_e <= r_mem[mem_ra];
        r_rd_v <= r_vld[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[mem_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_mode <= n_mode; r_slot <= n_slot; r_cmd <= n_cmd; r_down <= n_down;
        r_idx <= n_idx; r_jdx <= n_jdx; r_total <= n_total; r_have <= n_have;
        r_best <= n_best; r_best_e <= n_best_e; r_cur <= n_cur; r_min <= n_min;
        r_other <= n_other; r_count <= n_count; r_rem <= n_rem; r_num <= n_num;
        r_quo <= n_quo; r_cnt <= n_cnt; r_res <= n_res; r_out <= n_out;
    end

    always_comb begin
        n_state = r_state; n_mode = r_mode; n_slot = r_slot; n_cmd = r_cmd;
        n_down = r_down; n_idx = r_idx; n_jdx = r_jdx; n_total = r_total;
        n_have = r_have; n_best = r_best; n_best_e = r_best_e; n_cur = r_cur;
        n_min = r_min; n_other = r_other; n_count = r_count; n_rem = r_rem;
        n_num = r_num; n_quo = r_quo; n_cnt = r_cnt; n_res = r_res; n_out = r_out;
        n_ov = r_ov;
        mem_we = 1'b0; mem_wa = r_idx; mem_ra = r_idx; mem_wd = r_cur;
        rem_sh = {r_rem, r_num[NW-1]};
        wb = weight_of(r_best_e.nice);
        vsum = '0;
        i_req.ready = (r_state == ST_IDLE);

        if (r_ov && o_rsp.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_mode = i_req.mode;
                    n_slot = i_req.slot;
                    n_cmd  = '{state: i_req.new_state, nice: i_req.new_nice,
                               vr: i_req.new_vruntime, chan: i_req.channel};
                    n_down = i_req.shift_down;
                    n_idx = '0; n_total = '0; n_have = 1'b0; n_count = '0;
                    n_res = '0;
                    unique case (i_req.mode)
                        MD_PICK:  n_state = ST_PK_RD;
                        MD_WAKE:  n_state = ST_WK_RD;
                        MD_WRITE: n_state = ST_RD_EV;
                        MD_READ:  n_state = ST_RD_AD;
                        MD_SHIFT: n_state = ST_SH_RD;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_PK_RD: begin
                n_state = ST_PK_EV;
            end
            ST_PK_EV: begin
                if (rd_e.state == RS_RUNNABLE) begin
                    n_total = r_total + TW'(weight_of(rd_e.nice));
                    if (!r_have || rd_e.vr < r_best_e.vr) begin
                        n_have = 1'b1; n_best = r_idx; n_best_e = rd_e;
                    end
                end
                if (r_idx == LAST) begin
                    n_state = n_have ? ST_PK_SET : ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = ST_PK_RD;
                end
            end
            ST_PK_SET: begin
                n_num = NW'(SLICE_SCALE) * NW'(wb) + NW'(r_total) - 1'b1;
                n_rem = '0; n_quo = '0; n_cnt = CW'(NW);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_num = r_num << 1;
                if (rem_sh >= {1'b0, r_total}) begin
                    n_rem = TW'(rem_sh - {1'b0, r_total});
                    n_quo = {r_quo[NW-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[TW-1:0];
                    n_quo = {r_quo[NW-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) n_state = ST_PK_WR;
            end
            ST_PK_WR: begin
                mem_we = 1'b1; mem_wa = r_best;
                mem_wd = r_best_e; mem_wd.state = RS_RUNNING;
                n_res.found = 1'b1;
                n_res.chosen_slot = 6'(r_best);
                n_res.weight = wb;
                n_res.slice_ticks = r_quo[13:0];
                n_res.slot_state = RS_RUNNING;
                n_res.slot_nice = r_best_e.nice;
                n_res.slot_vruntime = r_best_e.vr;
                n_state = ST_DONE;
            end
            ST_WK_RD: begin
                n_state = ST_WK_EV;
            end
            ST_WK_EV: begin
                if (rd_e.state == RS_SLEEPING && rd_e.chan == r_cmd.chan) begin
                    n_cur = rd_e; n_jdx = '0; n_min = '0; n_other = 1'b0;
                    n_state = ST_WK_IRD;
                end else if (r_idx == LAST) begin
                    n_res.woken_count = r_count;
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = ST_WK_RD;
                end
            end
            ST_WK_IRD: begin
                mem_ra = r_jdx;
                n_state = ST_WK_IEV;
            end
            ST_WK_IEV: begin
                if (r_jdx != r_idx &&
                    (rd_e.state == RS_RUNNABLE || rd_e.state == RS_RUNNING)) begin
                    n_other = 1'b1;
                    if (rd_e.vr < r_min) n_min = rd_e.vr;
                end
                if (r_jdx == LAST) begin
                    n_state = ST_WK_WR;
                end else begin
                    n_jdx = r_jdx + 1'b1;
                    n_state = ST_WK_IRD;
                end
            end
            ST_WK_WR: begin
                vsum = 33'(r_min) - $signed({21'b0, tick_of(r_cur.nice)});
                mem_we = 1'b1;
                mem_wd = r_cur;
                mem_wd.state = RS_RUNNABLE;
                mem_wd.vr = r_other ? sat32(vsum) : '0;
                n_count = r_count + 1'b1;
                if (r_idx == LAST) begin
                    n_res.woken_count = n_count;
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = ST_WK_RD;
                end
            end
            ST_SH_RD: begin
                n_state = ST_SH_EV;
            end
            ST_SH_EV: begin
                vsum = r_down ? 33'(rd_e.vr) - SHIFT_STEP : 33'(rd_e.vr) + SHIFT_STEP;
                if (rd_e.state == RS_SLEEPING || rd_e.state == RS_RUNNABLE ||
                    rd_e.state == RS_RUNNING) begin
                    mem_we = 1'b1;
                    mem_wd = rd_e;
                    mem_wd.vr = sat32(vsum);
                end
                if (r_idx == LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = ST_SH_RD;
                end
            end
            ST_RD_AD: begin
                mem_ra = IW'(r_slot);
                n_state = ST_RD_EV;
            end
            ST_RD_EV: begin
                // write requests pass here too and update the slot if it is in range
                if (r_mode == MD_WRITE) begin
                    mem_we = slot_ok; mem_wa = IW'(r_slot); mem_wd = r_cmd;
                end else if (slot_ok) begin
                    n_res.found = 1'b1;
                    n_res.chosen_slot = r_slot;
                    n_res.slot_state = rd_e.state;
                    n_res.slot_nice = rd_e.nice;
                    n_res.slot_vruntime = rd_e.vr;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_out = r_res;
                    n_ov = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_rsp.valid = r_ov;
    assign o_rsp.found = r_out.found;
    assign o_rsp.chosen_slot = r_out.chosen_slot;
    assign o_rsp.weight = r_out.weight;
    assign o_rsp.slice_ticks = r_out.slice_ticks;
    assign o_rsp.slot_state = r_out.slot_state;
    assign o_rsp.slot_nice = r_out.slot_nice;
    assign o_rsp.slot_vruntime = r_out.slot_vruntime;
    assign o_rsp.woken_count = r_out.woken_count;

endmodule
